/* hdl/rtp_pkg.sv */
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types and constants for the repeating timer pool.
// ----------------------------------------------------------------------------
package rtp_pkg;

  localparam int TIMER_COUNT = 16;
  localparam int TIDX_W      = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CNT_W       = $clog2(TIMER_COUNT + 1);
  localparam int RANGE_W     = 7;

  localparam int TIME_W   = 48;
  localparam int PERIOD_W = 32;
  localparam int CALLS_W  = 17;

  // Call count that repeats forever (-1 in 17 bits)
  localparam logic [CALLS_W-1:0] CALLS_FOREVER = {CALLS_W{1'b1}};

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;
  localparam logic [1:0] ACT_STOP  = 2'd3;

  localparam logic [1:0] EV_FIRED    = 2'd0;
  localparam logic [1:0] EV_ACCEPTED = 2'd1;
  localparam logic [1:0] EV_REJECTED = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic [CALLS_W-1:0]  init_calls;
    logic [CALLS_W-1:0]  rem_calls;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   due;
  } tmr_entry_t;

endpackage

/* hdl/repeating_timer_pool_core.sv */
// ----------------------------------------------------------------------------
// repeating_timer_pool_core
// Pool of periodic / one-shot timers held in a one-port-write, registered-read
// table; ticks sweep the table one entry per cycle while no held fire waits on a stalled output.
// ----------------------------------------------------------------------------
// Commands: a set, start or stop reads its entry, then sends its result to
//   the output register once that register is free. A new command or tick
//   waits until the last one is done. Sweep: the single table read port scans
//   one entry per cycle; output back-pressure holds it while fires queue up.
// Reset: synchronous, active low; clears time, enables, entry valid bits and
//   control. Table entries never written read as zero, so no clearing pass.
// ----------------------------------------------------------------------------
module repeating_timer_pool_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_timer_index,
  input  logic [31:0] in_period_ticks,
  input  logic signed [16:0] in_call_count,
  input  logic [31:0] in_start_delay,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_which_timer,
  output logic [1:0]  out_event_kind,
  output logic        out_last_of_run
);

  localparam int TC      = rtp_pkg::TIMER_COUNT;
  localparam int TIDX_W  = rtp_pkg::TIDX_W;
  localparam int CNT_W   = rtp_pkg::CNT_W;
  localparam int TIME_W  = rtp_pkg::TIME_W;
  localparam int CALLS_W = rtp_pkg::CALLS_W;

  // Timer table
  rtp_pkg::tmr_entry_t mem [TC];
  rtp_pkg::tmr_entry_t rdata_r;
  logic                rd_en;
  logic [TIDX_W-1:0]   rd_addr;
  logic                wr_en;
  logic [TIDX_W-1:0]   wr_addr;
  rtp_pkg::tmr_entry_t wr_data;

  rtp_pkg::state_t     state_r, state_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [TC-1:0]       en_r, en_nxt;
  logic [TC-1:0]       mval_r, mval_nxt;

  // Command registers
  logic [1:0]          cmd_act_r;
  logic [TIDX_W-1:0]   cmd_addr_r;
  logic [3:0]          cmd_idx_r;
  logic                cmd_in_range_r;
  logic [31:0]         cmd_period_r;
  logic [CALLS_W-1:0]  cmd_calls_r;
  logic [31:0]         cmd_delay_r;

  // Sweep control
  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic                ev_valid_r, ev_valid_nxt;
  logic [TIDX_W-1:0]   ev_idx_r, ev_idx_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [3:0]          pend_idx_r, pend_idx_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [3:0]          out_which_r, out_which_nxt;
  logic [1:0]          out_kind_r, out_kind_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_accept;
  logic                out_free;
  logic                push;
  logic                sweep_stall;

  rtp_pkg::tmr_entry_t ev_ent;
  rtp_pkg::tmr_entry_t cmd_ent;
  logic                ev_forever;
  logic                ev_has_calls;
  logic                ev_due;
  logic                ev_fire;
  logic [CALLS_W-1:0]  ev_rem_nxt;
  logic [TIME_W-1:0]   ev_diff;

  assign in_stall  = (state_r != rtp_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_which_timer = out_which_r;
  assign out_event_kind  = out_kind_r;
  assign out_last_of_run = out_last_r;

  // Entries never written read as reset value
  assign ev_ent  = mval_r[ev_idx_r]   ? rdata_r : '0;
  assign cmd_ent = mval_r[cmd_addr_r] ? rdata_r : '0;

  assign ev_forever   = (ev_ent.init_calls == rtp_pkg::CALLS_FOREVER);
  assign ev_has_calls = (!ev_ent.rem_calls[CALLS_W-1] && (ev_ent.rem_calls != '0))
                        || ev_forever;
  assign ev_diff      = time_r - ev_ent.due;
  assign ev_due       = !ev_diff[TIME_W-1];
  assign ev_fire      = ev_valid_r && en_r[ev_idx_r] && ev_has_calls && ev_due;
  assign ev_rem_nxt   = ev_forever ? ev_ent.rem_calls : ev_ent.rem_calls - 1'b1;
  assign sweep_stall  = ev_fire && pend_valid_r && !out_free;

  always_comb begin
    state_nxt      = state_r;
    time_nxt       = time_r;
    en_nxt         = en_r;
    mval_nxt       = mval_r;
    rd_cnt_nxt     = rd_cnt_r;
    ev_valid_nxt   = ev_valid_r;
    ev_idx_nxt     = ev_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    push           = 1'b0;
    out_which_nxt  = out_which_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      rtp_pkg::ST_IDLE: begin
        if (in_accept) begin
          rd_en = 1'b1;
          if (in_action == rtp_pkg::ACT_TICK) begin
            // Read entry 0 now, evaluate it next cycle against the new time
            time_nxt     = time_r + 1'b1;
            rd_addr      = '0;
            rd_cnt_nxt   = CNT_W'(1);
            ev_valid_nxt = 1'b1;
            ev_idx_nxt   = '0;
            state_nxt    = rtp_pkg::ST_SWEEP;
          end else begin
            rd_addr   = TIDX_W'(in_timer_index);
            state_nxt = rtp_pkg::ST_CMD;
          end
        end
      end

      rtp_pkg::ST_CMD: begin
        if (out_free) begin
          push          = 1'b1;
          out_which_nxt = cmd_idx_r;
          out_last_nxt  = 1'b1;
          out_kind_nxt  = rtp_pkg::EV_REJECTED;
          wr_addr       = cmd_addr_r;
          wr_data       = cmd_ent;
          if (cmd_in_range_r) begin
            case (cmd_act_r)
              rtp_pkg::ACT_SET: begin
                wr_en              = 1'b1;
                wr_data.period     = cmd_period_r;
                wr_data.init_calls = cmd_calls_r;
                wr_data.rem_calls  = cmd_calls_r;
                en_nxt[cmd_addr_r] = 1'b0;
                out_kind_nxt       = rtp_pkg::EV_ACCEPTED;
              end
              rtp_pkg::ACT_START: begin
                if (!en_r[cmd_addr_r]) begin
                  wr_en              = 1'b1;
                  wr_data.rem_calls  = cmd_ent.init_calls;
                  wr_data.due        = time_r + TIME_W'(cmd_delay_r);
                  en_nxt[cmd_addr_r] = 1'b1;
                  out_kind_nxt       = rtp_pkg::EV_ACCEPTED;
                end
              end
              rtp_pkg::ACT_STOP: begin
                if (en_r[cmd_addr_r]) begin
                  en_nxt[cmd_addr_r] = 1'b0;
                  out_kind_nxt       = rtp_pkg::EV_ACCEPTED;
                end
              end
              default: begin
              end
            endcase
          end
          if (wr_en) begin
            mval_nxt[cmd_addr_r] = 1'b1;
          end
          state_nxt = rtp_pkg::ST_IDLE;
        end
      end

      rtp_pkg::ST_SWEEP: begin
        if (!ev_valid_r && rd_cnt_r == CNT_W'(TC)) begin
          // Sweep done: release the held fire as the last of the run
          if (!pend_valid_r) begin
            state_nxt = rtp_pkg::ST_IDLE;
          end else if (out_free) begin
            push           = 1'b1;
            out_which_nxt  = pend_idx_r;
            out_kind_nxt   = rtp_pkg::EV_FIRED;
            out_last_nxt   = 1'b1;
            pend_valid_nxt = 1'b0;
            state_nxt      = rtp_pkg::ST_IDLE;
          end
        end else if (!sweep_stall) begin
          if (ev_fire) begin
            wr_en            = 1'b1;
            wr_addr          = ev_idx_r;
            wr_data          = ev_ent;
            wr_data.rem_calls = ev_rem_nxt;
            mval_nxt[ev_idx_r] = 1'b1;
            if (ev_rem_nxt == '0) begin
              en_nxt[ev_idx_r] = 1'b0;
            end else begin
              wr_data.due = time_r + TIME_W'(ev_ent.period);
            end
            // Hold the newest fire; pass the previous one on as not last
            if (pend_valid_r) begin
              push          = 1'b1;
              out_which_nxt = pend_idx_r;
              out_kind_nxt  = rtp_pkg::EV_FIRED;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = 4'(ev_idx_r);
          end
          if (rd_cnt_r < CNT_W'(TC)) begin
            rd_en        = 1'b1;
            rd_addr      = rd_cnt_r[TIDX_W-1:0];
            rd_cnt_nxt   = rd_cnt_r + 1'b1;
            ev_valid_nxt = 1'b1;
            ev_idx_nxt   = rd_cnt_r[TIDX_W-1:0];
          end else begin
            ev_valid_nxt = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = rtp_pkg::ST_IDLE;
      end
    endcase

    if (push) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  // Table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rtp_pkg::ST_IDLE;
      time_r       <= '0;
      en_r         <= '0;
      mval_r       <= '0;
      rd_cnt_r     <= '0;
      ev_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      time_r       <= time_nxt;
      en_r         <= en_nxt;
      mval_r       <= mval_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      ev_valid_r   <= ev_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r    <= ev_idx_nxt;
    pend_idx_r  <= pend_idx_nxt;
    out_which_r <= out_which_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
    if (in_accept) begin
      cmd_act_r      <= in_action;
      cmd_addr_r     <= TIDX_W'(in_timer_index);
      cmd_idx_r      <= in_timer_index;
      cmd_in_range_r <= ({{(rtp_pkg::RANGE_W-4){1'b0}}, in_timer_index}
                         < rtp_pkg::RANGE_W'(TC));
      cmd_period_r   <= in_period_ticks;
      cmd_calls_r    <= in_call_count;
      cmd_delay_r    <= in_start_delay;
    end
  end

  // Idle means no fire is held back and no entry is in evaluation
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtp_pkg::ST_IDLE) |-> (!pend_valid_r && !ev_valid_r))
    else $error("held fire or evaluation left over in idle");

  // Never overwrite a result that is still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !push)
    else $error("result overwritten while stalled");

  // A stalled sweep keeps the entry under evaluation
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtp_pkg::ST_SWEEP && sweep_stall)
      |=> ($stable(ev_idx_r) && ev_valid_r && $stable(rd_cnt_r)))
    else $error("sweep advanced under stall");

  // Never write the table during idle; the single write port allows one write per cycle
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtp_pkg::ST_IDLE) |-> !wr_en)
    else $error("table written while idle");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the repeating timer pool: a queue-fed driver pushes
// set/start/stop/tick items, a scoreboard model predicts the fire and command
// events, and a monitor compares every event leaving the block in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_MAX     = 10;
  localparam int QUIET_TAIL     = 30;

  typedef struct {
    logic [1:0]                         action;
    logic [rtp_pkg::TIDX_W-1:0]         idx;
    logic [rtp_pkg::PERIOD_W-1:0]       period;
    logic signed [rtp_pkg::CALLS_W-1:0] calls;
    logic [rtp_pkg::PERIOD_W-1:0]       delay;
    bit                                 drain;
  } pool_cmd_t;

  typedef struct {
    logic [3:0] which;
    logic [1:0] kind;
    logic       last;
  } timer_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = rtp_pkg::ACT_TICK;
  logic [3:0]  in_timer_index = '0;
  logic [31:0] in_period_ticks = '0;
  logic signed [16:0] in_call_count = '0;
  logic [31:0] in_start_delay = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_which_timer;
  logic [1:0]  out_event_kind;
  logic        out_last_of_run;

  repeating_timer_pool_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_timer_index  (in_timer_index),
    .in_period_ticks (in_period_ticks),
    .in_call_count   (in_call_count),
    .in_start_delay  (in_start_delay),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_which_timer (out_which_timer),
    .out_event_kind  (out_event_kind),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the timer table
  logic [rtp_pkg::TIME_W-1:0]         now_ticks;
  bit                                 armed      [rtp_pkg::TIMER_COUNT];
  logic signed [rtp_pkg::CALLS_W-1:0] calls_init [rtp_pkg::TIMER_COUNT];
  logic signed [rtp_pkg::CALLS_W-1:0] calls_left [rtp_pkg::TIMER_COUNT];
  logic [rtp_pkg::PERIOD_W-1:0]       period_of  [rtp_pkg::TIMER_COUNT];
  logic [rtp_pkg::TIME_W-1:0]         due_at     [rtp_pkg::TIMER_COUNT];

  pool_cmd_t    cmd_q[$];
  timer_event_t timer_events_q[$];

  int  total_cmds = 0;
  int  accepted_cmds = 0;
  int  errors = 0;
  int  stuck_cycles = 0;
  int  idle_left = 0;
  int  stall_left = 0;
  bit  in_taken = 1'b0;
  bit  progress;
  pool_cmd_t    drive_cmd;
  pool_cmd_t    seen_cmd;
  timer_event_t seen_ev;
  timer_event_t want_ev;

  task automatic predict_timer_events(input pool_cmd_t c);
    timer_event_t               ev;
    bit                         forever_run;
    bit                         ok;
    int                         fired;
    logic [rtp_pkg::TIME_W-1:0] lag;
    if (c.action == rtp_pkg::ACT_TICK) begin
      now_ticks = now_ticks + 1'b1;
      fired = 0;
      for (int i = 0; i < rtp_pkg::TIMER_COUNT; i++) begin
        forever_run = (calls_init[i] == rtp_pkg::CALLS_FOREVER);
        if (!armed[i]) continue;
        if (!(calls_left[i] > 0 || forever_run)) continue;
        // due when the wrapped distance past the due time is non-negative
        lag = now_ticks - due_at[i];
        if (lag[rtp_pkg::TIME_W-1]) continue;
        if (!forever_run) calls_left[i] = calls_left[i] - 1;
        if (calls_left[i] == 0) begin
          armed[i] = 1'b0;
        end else begin
          due_at[i] = now_ticks + period_of[i];
        end
        ev.which = 4'(i);
        ev.kind  = rtp_pkg::EV_FIRED;
        ev.last  = 1'b0;
        timer_events_q.push_back(ev);
        fired++;
      end
      if (fired > 0) timer_events_q[timer_events_q.size()-1].last = 1'b1;
    end else begin
      ok = 1'b0;
      if (c.idx < rtp_pkg::TIMER_COUNT) begin
        case (c.action)
          rtp_pkg::ACT_SET: begin
            period_of[c.idx]  = c.period;
            calls_init[c.idx] = c.calls;
            calls_left[c.idx] = c.calls;
            armed[c.idx]      = 1'b0;
            ok = 1'b1;
          end
          rtp_pkg::ACT_START: begin
            if (!armed[c.idx]) begin
              armed[c.idx]      = 1'b1;
              calls_left[c.idx] = calls_init[c.idx];
              due_at[c.idx]     = now_ticks + c.delay;
              ok = 1'b1;
            end
          end
          default: begin
            if (armed[c.idx]) begin
              armed[c.idx] = 1'b0;
              ok = 1'b1;
            end
          end
        endcase
      end
      ev.which = c.idx;
      ev.kind  = ok ? rtp_pkg::EV_ACCEPTED : rtp_pkg::EV_REJECTED;
      ev.last  = 1'b1;
      timer_events_q.push_back(ev);
    end
  endtask

  task automatic add_cmd(input logic [1:0] action, input int idx,
                         input logic [31:0] period, input logic [16:0] calls,
                         input logic [31:0] delay);
    pool_cmd_t c;
    c.action = action;
    c.idx    = idx[rtp_pkg::TIDX_W-1:0];
    c.period = period;
    c.calls  = calls;
    c.delay  = delay;
    c.drain  = 1'b0;
    cmd_q.push_back(c);
    total_cmds++;
  endtask

  task automatic add_drain();
    pool_cmd_t c;
    c = '{rtp_pkg::ACT_TICK, '0, '0, '0, '0, 1'b1};
    cmd_q.push_back(c);
  endtask

  // Driver: hold a stalled item, otherwise idle or advance to the next one
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_valid && !in_taken)) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0 && cmd_q[0].drain) begin
          // hold off until every outstanding event has come out
          in_valid <= 1'b0;
          if (timer_events_q.size() == 0) void'(cmd_q.pop_front());
        end else if (cmd_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
          idle_left = $urandom_range(1, 8) - 1;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          drive_cmd = cmd_q.pop_front();
          in_valid        <= 1'b1;
          in_action       <= drive_cmd.action;
          in_timer_index  <= drive_cmd.idx;
          in_period_ticks <= drive_cmd.period;
          in_call_count   <= drive_cmd.calls;
          in_start_delay  <= drive_cmd.delay;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure in bursts, none near the end
  always @(negedge clk) begin
    if (rst_n) begin
      if (cmd_q.size() <= QUIET_TAIL) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor, scoreboard and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      progress = 1'b0;
      in_taken = in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        seen_cmd.action = in_action;
        seen_cmd.idx    = in_timer_index;
        seen_cmd.period = in_period_ticks;
        seen_cmd.calls  = in_call_count;
        seen_cmd.delay  = in_start_delay;
        seen_cmd.drain  = 1'b0;
        predict_timer_events(seen_cmd);
        accepted_cmds++;
        progress = 1'b1;
      end
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        seen_ev.which = out_which_timer;
        seen_ev.kind  = out_event_kind;
        seen_ev.last  = out_last_of_run;
        if (timer_events_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: unexpected event: timer %0d kind %0d last %0b",
                     $realtime, seen_ev.which, seen_ev.kind, seen_ev.last);
        end else begin
          want_ev = timer_events_q.pop_front();
          if (seen_ev.which !== want_ev.which || seen_ev.kind !== want_ev.kind ||
              seen_ev.last !== want_ev.last) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("%0t: mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                       $realtime, want_ev.which, want_ev.kind, want_ev.last,
                       seen_ev.which, seen_ev.kind, seen_ev.last);
          end
        end
      end
      stuck_cycles = progress ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no traffic for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int          r;
    logic [1:0]  act;
    int          idx;
    logic [31:0] period;
    logic [16:0] calls;
    logic [31:0] delay;

    now_ticks = '0;
    for (int i = 0; i < rtp_pkg::TIMER_COUNT; i++) begin
      armed[i]      = 1'b0;
      calls_init[i] = '0;
      calls_left[i] = '0;
      period_of[i]  = '0;
      due_at[i]     = '0;
    end

    // One-shot with zero period, double start, stop on a finished timer
    add_cmd(rtp_pkg::ACT_SET,   0, 32'd0, 17'd1, 32'd0);
    add_cmd(rtp_pkg::ACT_START, 0, 32'd0, 17'd0, 32'd0);
    add_cmd(rtp_pkg::ACT_START, 0, 32'd0, 17'd0, 32'd5);
    add_cmd(rtp_pkg::ACT_TICK,  0, 32'd0, 17'd0, 32'd0);
    add_cmd(rtp_pkg::ACT_STOP,  0, 32'd0, 17'd0, 32'd0);
    // Forever timer, extreme period and delay, counts that never fire
    add_cmd(rtp_pkg::ACT_SET,   1, 32'd2, rtp_pkg::CALLS_FOREVER, 32'd0);
    add_cmd(rtp_pkg::ACT_START, 1, 32'd0, 17'd0, 32'd1);
    add_cmd(rtp_pkg::ACT_SET,   15, 32'hFFFF_FFFF, 17'h0FFFF, 32'hFFFF_FFFF);
    add_cmd(rtp_pkg::ACT_START, 15, 32'hFFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF);
    add_cmd(rtp_pkg::ACT_SET,   3, 32'd1, 17'd0, 32'd0);
    add_cmd(rtp_pkg::ACT_START, 3, 32'd0, 17'd0, 32'd0);
    add_cmd(rtp_pkg::ACT_SET,   4, 32'd1, 17'h1FFFE, 32'd0);
    add_cmd(rtp_pkg::ACT_START, 4, 32'd0, 17'd0, 32'd0);
    add_cmd(rtp_pkg::ACT_SET,   5, 32'd1, 17'h10000, 32'd0);
    add_cmd(rtp_pkg::ACT_START, 5, 32'd0, 17'd0, 32'd0);
    add_cmd(rtp_pkg::ACT_SET,   2, 32'd0, 17'd3, 32'd0);
    add_cmd(rtp_pkg::ACT_START, 2, 32'd0, 17'd0, 32'd0);
    repeat (4) add_cmd(rtp_pkg::ACT_TICK, 0, 32'd0, 17'd0, 32'd0);
    add_cmd(rtp_pkg::ACT_STOP,  1, 32'd0, 17'd0, 32'd0);
    add_cmd(rtp_pkg::ACT_STOP,  15, 32'd0, 17'd0, 32'd0);
    add_cmd(rtp_pkg::ACT_TICK,  15, 32'hFFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF);
    add_drain();

    // Random part: mostly small periods, counts and delays on a few timers
    for (int n = 0; n < 200; n++) begin
      if (n == 100) add_drain();
      r = $urandom_range(0, 99);
      if (r < 45)      act = rtp_pkg::ACT_TICK;
      else if (r < 65) act = rtp_pkg::ACT_SET;
      else if (r < 85) act = rtp_pkg::ACT_START;
      else             act = rtp_pkg::ACT_STOP;
      idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5) : $urandom_range(0, 15);
      period = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 6)) : $urandom;
      case ($urandom_range(0, 9))
        0, 1:    calls = rtp_pkg::CALLS_FOREVER;
        8:       calls = 17'($urandom);
        9:       calls = 17'h0FFFF;
        default: calls = 17'($urandom_range(0, 5));
      endcase
      delay = ($urandom_range(0, 19) < 17) ? 32'($urandom_range(0, 8)) : $urandom;
      add_cmd(act, idx, period, calls, delay);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (!(accepted_cmds == total_cmds && timer_events_q.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && timer_events_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
